// ===== rtl/atfb_pkg.sv =====
// ----------------------------------------------------------------------------
// atfb_pkg
// Types, constants and the header byte selector of the API transmit frame
// builder.
// ----------------------------------------------------------------------------
package atfb_pkg;

    localparam logic [7:0]  START_DELIM     = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE      = 8'h10;
    localparam logic [15:0] HEADER_OVERHEAD = 16'h000E;
    localparam logic [7:0]  CHECK_BASE      = 8'hFF;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_DEST_LONG  = 3'd0;
    localparam t_cfg_idx REG_DEST_SHORT = 3'd1;
    localparam t_cfg_idx REG_FRAME_ID   = 3'd2;
    localparam t_cfg_idx REG_HOP_RADIUS = 3'd3;
    localparam t_cfg_idx REG_TX_OPTIONS = 3'd4;

    // beat position within one input item; header occupies 0..16
    typedef logic [4:0] t_step;

    localparam t_step STEP_START   = 5'd0;
    localparam t_step STEP_LEN_HI  = 5'd1;
    localparam t_step STEP_LEN_LO  = 5'd2;
    localparam t_step STEP_TYPE    = 5'd3;
    localparam t_step STEP_ID      = 5'd4;
    localparam t_step STEP_LONG_0  = 5'd5;
    localparam t_step STEP_LONG_1  = 5'd6;
    localparam t_step STEP_LONG_2  = 5'd7;
    localparam t_step STEP_LONG_3  = 5'd8;
    localparam t_step STEP_LONG_4  = 5'd9;
    localparam t_step STEP_LONG_5  = 5'd10;
    localparam t_step STEP_LONG_6  = 5'd11;
    localparam t_step STEP_LONG_7  = 5'd12;
    localparam t_step STEP_SHORT_0 = 5'd13;
    localparam t_step STEP_SHORT_1 = 5'd14;
    localparam t_step STEP_RADIUS  = 5'd15;
    localparam t_step STEP_OPTIONS = 5'd16;
    localparam t_step STEP_PAYLOAD = 5'd17;
    localparam t_step STEP_CKSUM   = 5'd18;

    typedef struct packed {
        logic [63:0] dest_long;
        logic [15:0] dest_short;
        logic [7:0]  frame_id;
        logic [7:0]  hop_radius;
        logic [7:0]  tx_options;
    } t_cfg;

    function automatic logic [7:0] hdr_byte(input t_step step, input t_cfg cfg,
                                            input logic [15:0] flen);
        logic [7:0] b;
        b = 8'h00;
        case (step)
            STEP_START:   b = START_DELIM;
            STEP_LEN_HI:  b = flen[15:8];
            STEP_LEN_LO:  b = flen[7:0];
            STEP_TYPE:    b = FRAME_TYPE;
            STEP_ID:      b = cfg.frame_id;
            STEP_LONG_0:  b = cfg.dest_long[63:56];
            STEP_LONG_1:  b = cfg.dest_long[55:48];
            STEP_LONG_2:  b = cfg.dest_long[47:40];
            STEP_LONG_3:  b = cfg.dest_long[39:32];
            STEP_LONG_4:  b = cfg.dest_long[31:24];
            STEP_LONG_5:  b = cfg.dest_long[23:16];
            STEP_LONG_6:  b = cfg.dest_long[15:8];
            STEP_LONG_7:  b = cfg.dest_long[7:0];
            STEP_SHORT_0: b = cfg.dest_short[15:8];
            STEP_SHORT_1: b = cfg.dest_short[7:0];
            STEP_RADIUS:  b = cfg.hop_radius;
            STEP_OPTIONS: b = cfg.tx_options;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/atfb_in_if.sv =====
// ----------------------------------------------------------------------------
// atfb_in_if
// Payload byte channel: valid/ready handshake with byte and frame length.
// ----------------------------------------------------------------------------
interface atfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [6:0] payload_len;

    modport source (output valid, output payload_byte, output payload_len, input ready);
    modport sink   (input valid, input payload_byte, input payload_len, output ready);
endinterface

// ===== rtl/atfb_out_if.sv =====
// ----------------------------------------------------------------------------
// atfb_out_if
// Frame byte channel: valid/ready handshake with byte and end-of-frame flag.
// ----------------------------------------------------------------------------
interface atfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== rtl/api_transmit_frame_builder.sv =====
// ----------------------------------------------------------------------------
// api_transmit_frame_builder
// Wraps payload bytes in API transmit request frames: header, payload, checksum.
// ----------------------------------------------------------------------------
// Data path: a payload byte inside a frame is held in the item slot, then in the
//   output register; the first byte of a frame is preceded by 17 header beats.
// Throughput: one output beat per cycle while the sink is ready; mid-frame bytes
//   are then taken every cycle; a first byte holds the slot through the header,
//   its payload beat and (if last) the checksum, a last byte up to its checksum.
// Reset: synchronous, active low; clears control state and loads the register
//   defaults; no clearing pass.
module api_transmit_frame_builder
    import atfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    atfb_in_if.sink              i_payload,
    atfb_out_if.source           o_frame
);

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    t_cfg        r_cfg;
    logic [6:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_sum, n_sum;

    // item slot
    logic        r_busy, n_busy;
    logic        r_hdr, n_hdr;
    logic        r_last, n_last;
    logic [7:0]  r_byte, n_byte;
    logic [15:0] r_flen, n_flen;
    t_step       r_step, n_step;

    // output register
    logic        r_ov, n_ov;
    logic [7:0]  r_ob, n_ob;
    logic        r_oe, n_oe;

    logic        acc, push, done;
    logic [6:0]  sat_len;
    logic [7:0]  beat_byte;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_long  <= 64'h0000_0000_0000_FFFF;
            r_cfg.dest_short <= 16'hFFFE;
            r_cfg.frame_id   <= 8'h01;
            r_cfg.hop_radius <= 8'h00;
            r_cfg.tx_options <= 8'h00;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEST_LONG:  r_cfg.dest_long  <= i_cfg_data;
                REG_DEST_SHORT: r_cfg.dest_short <= i_cfg_data[15:0];
                REG_FRAME_ID:   r_cfg.frame_id   <= i_cfg_data[7:0];
                REG_HOP_RADIUS: r_cfg.hop_radius <= i_cfg_data[7:0];
                REG_TX_OPTIONS: r_cfg.tx_options <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign push = r_busy && (!r_ov || o_frame.ready);
    assign done = (r_step == STEP_CKSUM) || (r_step == STEP_PAYLOAD && !r_last);
    assign i_payload.ready = !r_busy || (push && done);
    assign acc = i_payload.valid && i_payload.ready;

    assign sat_len = ({1'b0, i_payload.payload_len} > MaxLen) ? MaxLen[6:0]
                                                               : i_payload.payload_len;

    always_comb begin
        case (r_step)
            STEP_PAYLOAD: beat_byte = r_byte;
            STEP_CKSUM:   beat_byte = CHECK_BASE - r_sum;
            default:      beat_byte = hdr_byte(r_step, r_cfg, r_flen);
        endcase
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_busy = r_busy;
        n_hdr  = r_hdr;
        n_last = r_last;
        n_byte = r_byte;
        n_flen = r_flen;
        n_step = r_step;
        n_sum  = r_sum;
        n_ov   = r_ov;
        n_ob   = r_ob;
        n_oe   = r_oe;

        if (push) begin
            n_ov = 1'b1;
            n_ob = beat_byte;
            n_oe = (r_step == STEP_CKSUM);
            if (r_step == STEP_TYPE) begin
                n_sum = FRAME_TYPE;
            end else if (r_step > STEP_TYPE && r_step <= STEP_PAYLOAD) begin
                n_sum = r_sum + beat_byte;
            end
            n_step = r_step + t_step'(1);
            if (done) begin
                n_busy = 1'b0;
            end
        end else if (o_frame.ready) begin
            n_ov = 1'b0;
        end

        if (acc) begin
            n_byte = i_payload.payload_byte;
            if (r_bytes_left == 7'd0) begin
                // zero length starts no frame: the beat is dropped
                if (sat_len != 7'd0) begin
                    n_busy = 1'b1;
                    n_hdr  = 1'b1;
                    n_step = STEP_START;
                    n_last = (sat_len == 7'd1);
                    n_flen = HEADER_OVERHEAD + 16'(sat_len);
                    n_bytes_left = sat_len - 7'd1;
                end
            end else begin
                n_busy = 1'b1;
                n_hdr  = 1'b0;
                n_step = STEP_PAYLOAD;
                n_last = (r_bytes_left == 7'd1);
                n_bytes_left = r_bytes_left - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 7'd0;
            r_sum        <= 8'd0;
            r_busy       <= 1'b0;
            r_ov         <= 1'b0;
            r_step       <= STEP_START;
            r_hdr        <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_busy       <= n_busy;
            r_ov         <= n_ov;
            r_step       <= n_step;
            r_hdr        <= n_hdr;
            r_last       <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_flen <= n_flen;
        r_ob   <= n_ob;
        r_oe   <= n_oe;
    end

    assign o_frame.valid      = r_ov;
    assign o_frame.frame_byte = r_ob;
    assign o_frame.frame_end  = r_oe;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= STEP_CKSUM)
        else $error("item step out of range");

    a_mid_frame_skips_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_hdr) |-> (r_step == STEP_PAYLOAD || r_step == STEP_CKSUM))
        else $error("mid-frame item in header step");

    a_first_starts_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_bytes_left == 7'd0 && sat_len != 7'd0)
            |=> (r_busy && r_hdr && r_step == STEP_START))
        else $error("first byte did not start header");

    a_start_only_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_step == STEP_START) |-> r_hdr)
        else $error("start delimiter outside a header");

endmodule
